// ===== rtl/dstc_pkg.sv =====
// ----------------------------------------------------------------------------
// dstc_pkg: shared types and constants of the trace classifier
// Holds the default depth, the verdict codes and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none
package dstc_pkg;
	localparam int DEPTH_DEF = 1024;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
	localparam logic [2:0] VERDICT_NOT_SURE   = 3'd1;
	localparam logic [2:0] VERDICT_STACK      = 3'd2;
	localparam logic [2:0] VERDICT_QUEUE      = 3'd3;
	localparam logic [2:0] VERDICT_PRIORITY   = 3'd4;

	// Signed compare a > b on raw words.
	function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
		sgt = $signed(a) > $signed(b);
	endfunction

	typedef struct packed {
		logic start;
		logic push;
	} heap_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/dstc_heap.sv =====
// ----------------------------------------------------------------------------
// dstc_heap: binary max-heap with an iterative sift unit
// One memory, one compare unit; sifts one level per read-compare pass.
// ----------------------------------------------------------------------------
`default_nettype none
module dstc_heap
	import dstc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire heap_cmd_t   cmd,
	input  wire logic [31:0] value,
	input  wire logic [$clog2(DEPTH):0] count,
	output logic             done,
	output logic [31:0]      top
);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_UPRD  = 10'b0000000010,
		S_UPCMP = 10'b0000000100,
		S_RD0   = 10'b0000001000,
		S_LAST  = 10'b0000010000,
		S_CUR   = 10'b0000100000,
		S_RDL   = 10'b0001000000,
		S_RDR   = 10'b0010000000,
		S_DNCMP = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q, cur_q, best_q, top_q;
	logic [AW-1:0] idx_q, parent, addr, waddr;
	logic [AW:0] n_q, lidx, ridx;
	logic lgt_q, we, gt, rok, rgt;
	logic [31:0] cmp_a, cmp_b, wdata;

	// The value being sifted travels in cur_q and is written once it settles.
	assign parent = (idx_q - 1'b1) >> 1;
	assign lidx = {idx_q, 1'b1};
	assign ridx = lidx + 1'b1;
	assign rok = (ridx < n_q);
	assign rgt = rok && gt;

	always_comb begin
		cmp_a = rdata_q;
		cmp_b = cur_q;
		if (state_q == S_UPCMP) begin
			cmp_a = cur_q;
			cmp_b = rdata_q;
		end else if (state_q == S_DNCMP) begin
			cmp_b = best_q;
		end
	end

	assign gt = sgt(cmp_a, cmp_b);

	always_comb begin
		unique case (state_q)
			S_UPRD:  addr = parent;
			S_LAST:  addr = n_q[AW-1:0];
			S_RDL:   addr = lidx[AW-1:0];
			S_RDR:   addr = ridx[AW-1:0];
			default: addr = '0;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		unique case (state_q)
			S_UPRD:  we = (idx_q == '0);
			S_UPCMP: begin
				we = 1'b1;
				if (gt) wdata = rdata_q;
			end
			S_RDL:   we = (lidx >= n_q);
			S_DNCMP: begin
				we = 1'b1;
				wdata = rgt ? rdata_q : best_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign done = (state_q == S_DONE);
	assign top = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (cmd.start) state_q <= cmd.push ? S_UPRD : S_RD0;
				S_UPRD:  state_q <= (idx_q == '0) ? S_DONE : S_UPCMP;
				S_UPCMP: state_q <= gt ? S_UPRD : S_DONE;
				S_RD0:   state_q <= S_LAST;
				S_LAST:  state_q <= S_CUR;
				S_CUR:   state_q <= S_RDL;
				S_RDL:   state_q <= (lidx >= n_q) ? S_DONE : S_RDR;
				S_RDR:   state_q <= S_DNCMP;
				S_DNCMP: state_q <= (rgt || lgt_q) ? S_RDL : S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd.start) begin
				idx_q <= cmd.push ? count[AW-1:0] : '0;
				n_q <= count - 1'b1;
				cur_q <= value;
			end
			S_UPCMP: if (gt) idx_q <= parent;
			S_LAST:  top_q <= rdata_q;
			S_CUR:   cur_q <= rdata_q;
			S_RDR: begin
				lgt_q <= gt;
				best_q <= gt ? rdata_q : cur_q;
			end
			S_DNCMP: begin
				if (rgt) idx_q <= ridx[AW-1:0];
				else if (lgt_q) idx_q <= lidx[AW-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/data_structure_trace_classifier_top.sv =====
// ----------------------------------------------------------------------------
// data_structure_trace_classifier_top: stack, queue and max-heap trace checker
// With the heap idle or dead the result word is offered in T_OUT, the state after
// T_RD, which follows acceptance; a heap insert adds a parent read and a compare
// per level climbed and a heap remove two child reads and a compare per level
// descended. One word is in flight; in_ready returns the cycle after the result
// is taken.
// Reset clears all counts and sets all flags; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module data_structure_trace_classifier_top
	import dstc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic signed [31:0] value,
	input  wire logic        new_case,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             could_be_stack,
	output logic             could_be_queue,
	output logic             could_be_priority,
	output logic [2:0]       verdict,
	output logic             overflow
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [AW:0] FULL = CW'(DEPTH);

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_RD   = 5'b00010,
		T_HEAP = 5'b00100,
		T_WAIT = 5'b01000,
		T_OUT  = 5'b10000
	} tstate_t;

	tstate_t st_q;
	logic [AW:0] sc_q, fc_q, hc_q;
	logic [AW-1:0] fh_q;
	logic [2:0] fl_q;
	logic cmd_q, ovf_q;
	logic [31:0] val_q, srd_q, frd_q;
	logic [31:0] smem [DEPTH];
	logic [31:0] fmem [DEPTH];
	heap_cmd_t hcmd;
	logic hdone;
	logic [31:0] htop;
	logic [AW:0] sc_n, fc_n, hc_n;
	logic [2:0] fl_n;
	logic [AW-1:0] fh_n;
	logic [AW:0] fpos, fwa;

	// Effective state after an optional new case.
	assign sc_n = new_case ? '0 : sc_q;
	assign fc_n = new_case ? '0 : fc_q;
	assign hc_n = new_case ? '0 : hc_q;
	assign fl_n = new_case ? 3'b111 : fl_q;
	assign fh_n = new_case ? '0 : fh_q;
	assign fpos = {1'b0, fh_n} + fc_n;
	assign fwa = (fpos >= FULL) ? fpos - FULL : fpos;

	wire acc = in_valid && in_ready;
	assign in_ready = (st_q == T_IDLE);

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_INSERT && fl_n[0] && sc_n < FULL)
			smem[sc_n[AW-1:0]] <= value;
		if (acc && cmd == CMD_INSERT && fl_n[1] && fc_n < FULL)
			fmem[fwa[AW-1:0]] <= value;
		srd_q <= smem[sc_n[AW-1:0] - 1'b1];
		frd_q <= fmem[fh_n];
	end

	assign hcmd.start = (st_q == T_RD) && fl_q[2] &&
		(cmd_q == CMD_INSERT ? hc_q < FULL : hc_q != '0);
	assign hcmd.push = (cmd_q == CMD_INSERT);

	dstc_heap #(.DEPTH(DEPTH)) u_heap (
		.clk(clk), .arst_n(arst_n), .cmd(hcmd), .value(val_q),
		.count(hc_q),
		.done(hdone), .top(htop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE; sc_q <= '0; fc_q <= '0; hc_q <= '0; fh_q <= '0;
			fl_q <= 3'b111; ovf_q <= 1'b0; cmd_q <= 1'b0; val_q <= '0;
		end else begin
			unique case (st_q)
				T_IDLE: if (acc) begin
					cmd_q <= cmd; val_q <= value; ovf_q <= 1'b0;
					fl_q <= fl_n; sc_q <= sc_n; fc_q <= fc_n; hc_q <= hc_n;
					fh_q <= fh_n;
					st_q <= T_RD;
				end
				T_RD: begin
					if (cmd_q == CMD_INSERT) begin
						if (fl_q[0]) begin
							if (sc_q < FULL) sc_q <= sc_q + 1'b1; else ovf_q <= 1'b1;
						end
						if (fl_q[1]) begin
							if (fc_q < FULL) fc_q <= fc_q + 1'b1; else ovf_q <= 1'b1;
						end
						if (fl_q[2]) begin
							if (hc_q < FULL) hc_q <= hc_q + 1'b1; else ovf_q <= 1'b1;
						end
					end else begin
						if (fl_q[0]) begin
							if (sc_q == '0 || srd_q != val_q) fl_q[0] <= 1'b0;
							if (sc_q != '0) sc_q <= sc_q - 1'b1;
						end
						if (fl_q[1]) begin
							if (fc_q == '0 || frd_q != val_q) fl_q[1] <= 1'b0;
							if (fc_q != '0) begin
								fc_q <= fc_q - 1'b1;
								fh_q <= (fh_q == AW'(DEPTH-1)) ? '0 : fh_q + 1'b1;
							end
						end
						if (fl_q[2]) begin
							if (hc_q == '0) fl_q[2] <= 1'b0;
							else hc_q <= hc_q - 1'b1;
						end
					end
					st_q <= hcmd.start ? T_HEAP : T_OUT;
				end
				T_HEAP: if (hdone) begin
					if (cmd_q == CMD_REMOVE && htop != val_q) fl_q[2] <= 1'b0;
					st_q <= T_OUT;
				end
				T_WAIT: st_q <= T_OUT;
				T_OUT: if (out_ready) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid = (st_q == T_OUT);
	assign could_be_stack = fl_q[0];
	assign could_be_queue = fl_q[1];
	assign could_be_priority = fl_q[2];
	assign overflow = ovf_q;

	always_comb begin
		unique case (fl_q)
			3'b000: verdict = VERDICT_IMPOSSIBLE;
			3'b001: verdict = VERDICT_STACK;
			3'b010: verdict = VERDICT_QUEUE;
			3'b100: verdict = VERDICT_PRIORITY;
			default: verdict = VERDICT_NOT_SURE;
		endcase
	end
endmodule
`default_nettype wire
